FILE: rtl/hazard_warning_fusion_debounce_top_macros.svh
// Assertion macros shared by the hazard warning fusion modules.
`ifndef HAZARD_WARNING_FUSION_DEBOUNCE_TOP_MACROS_SVH
`define HAZARD_WARNING_FUSION_DEBOUNCE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HWFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define HWFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/hwfd_pkg.sv
// Types, codes and constants of the hazard warning fusion block.
`timescale 1ns / 1ps
package hwfd_pkg;

	localparam int DIST_BITS  = 16;
	localparam int CMP_W      = (DIST_BITS > 16) ? DIST_BITS : 16;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;
	localparam logic [7:0] STABLE_MAX = 8'd255;

	localparam logic signed [15:0] APPROACH_DANGER  = -16'sd200;
	localparam logic signed [15:0] APPROACH_WARNING = -16'sd150;

	localparam logic [1:0] FUNC_FRONT = 2'd0;
	localparam logic [1:0] FUNC_REAR  = 2'd1;
	localparam logic [1:0] FUNC_FRAME = 2'd2;
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	localparam logic [1:0] PLACE_CENTER = 2'd0;
	localparam logic [1:0] PLACE_LEFT   = 2'd1;
	localparam logic [1:0] PLACE_RIGHT  = 2'd2;
	localparam logic [1:0] PLACE_LOST   = 2'd3;

	localparam logic [1:0] COLOR_OTHER  = 2'd0;
	localparam logic [1:0] COLOR_RED    = 2'd1;
	localparam logic [1:0] COLOR_YELLOW = 2'd2;
	localparam logic [1:0] COLOR_GREEN  = 2'd3;

	localparam logic DIR_FRONT = 1'b0;
	localparam logic DIR_REAR  = 1'b1;

	typedef enum logic [2:0] {
		REG_DANGER     = 3'd0,
		REG_WARNING    = 3'd1,
		REG_ATTENTION  = 3'd2,
		REG_REAR_CLOSE = 3'd3,
		REG_LANE_WARN  = 3'd4,
		REG_LANE_ATT   = 3'd5,
		REG_DEBOUNCE   = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		LVL_SAFE      = 2'd0,
		LVL_ATTENTION = 2'd1,
		LVL_WARNING   = 2'd2,
		LVL_DANGER    = 2'd3
	} level_t;

	typedef enum logic [2:0] {
		SRC_FRONT = 3'd0,
		SRC_REAR  = 3'd1,
		SRC_LANE  = 3'd2,
		SRC_LIGHT = 3'd3,
		SRC_CROSS = 3'd4
	} src_t;

	typedef struct packed {
		level_t level;
		src_t   source;
		logic   dir;
	} choice_t;

	typedef struct packed {
		logic [15:0] danger;
		logic [15:0] warning;
		logic [15:0] attention;
		logic [15:0] rear_close;
		logic [10:0] lane_warn;
		logic [10:0] lane_att;
		logic [7:0]  debounce;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         func;
		logic [15:0]        target_distance;
		logic signed [15:0] target_speed;
		logic               lane_found;
		logic [1:0]         lane_place;
		logic signed [11:0] lane_offset;
		logic               light_found;
		logic [1:0]         light_color;
		logic               crossing_found;
	} item_t;

	typedef struct packed {
		logic [1:0] warn_level;
		logic [2:0] warn_source;
		logic       warn_direction;
		logic       warn_active;
	} result_t;

	localparam choice_t CHOICE_RESET = '{level: LVL_SAFE, source: SRC_FRONT, dir: DIR_FRONT};

endpackage

FILE: rtl/hwfd_item_if.sv
// Valid/ready channel interfaces for input items and results.
`timescale 1ns / 1ps
interface hwfd_item_if;
	logic            valid;
	logic            ready;
	hwfd_pkg::item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface hwfd_result_if;
	logic              valid;
	logic              ready;
	hwfd_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/hwfd_cfg.sv
// APB register file holding the fusion thresholds and debounce count.
`timescale 1ns / 1ps
module hwfd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hwfd_pkg::ADDR_W-1:0]  paddr,
	input  logic [hwfd_pkg::DATA_W-1:0]  pwdata,
	output logic [hwfd_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output hwfd_pkg::cfg_t               cfg
);
	import hwfd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.danger     <= 16'd50;
			cfg_q.warning    <= 16'd100;
			cfg_q.attention  <= 16'd200;
			cfg_q.rear_close <= 16'd500;
			cfg_q.lane_warn  <= 11'd717;
			cfg_q.lane_att   <= 11'd410;
			cfg_q.debounce   <= 8'd3;
		end else if (wr_en) begin
			unique case (idx)
				REG_DANGER:     cfg_q.danger     <= pwdata[15:0];
				REG_WARNING:    cfg_q.warning    <= pwdata[15:0];
				REG_ATTENTION:  cfg_q.attention  <= pwdata[15:0];
				REG_REAR_CLOSE: cfg_q.rear_close <= pwdata[15:0];
				REG_LANE_WARN:  cfg_q.lane_warn  <= pwdata[10:0];
				REG_LANE_ATT:   cfg_q.lane_att   <= pwdata[10:0];
				REG_DEBOUNCE:   cfg_q.debounce   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DANGER:     prdata = DATA_W'(cfg_q.danger);
			REG_WARNING:    prdata = DATA_W'(cfg_q.warning);
			REG_ATTENTION:  prdata = DATA_W'(cfg_q.attention);
			REG_REAR_CLOSE: prdata = DATA_W'(cfg_q.rear_close);
			REG_LANE_WARN:  prdata = DATA_W'(cfg_q.lane_warn);
			REG_LANE_ATT:   prdata = DATA_W'(cfg_q.lane_att);
			REG_DEBOUNCE:   prdata = DATA_W'(cfg_q.debounce);
			default:        prdata = '0;
		endcase
	end

endmodule

FILE: rtl/hwfd_front.sv
// Front end: accepts items, tracks radar state per frame and grades sources at frame end.
`timescale 1ns / 1ps
module hwfd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  hwfd_pkg::cfg_t     cfg,
	hwfd_item_if.sink          item,
	output logic               push,
	output hwfd_pkg::choice_t  push_data,
	input  logic               push_ready
);
	import hwfd_pkg::*;

	logic [DIST_BITS-1:0] front_near_q;
	logic                 front_any_q;
	logic [DIST_BITS-1:0] rear_near_q;
	logic signed [15:0]   rear_fast_q;
	logic                 rear_any_q;

	logic                 accept;
	logic [DIST_BITS-1:0] tgt_dist;
	level_t               g_front, g_rear, g_lane, g_light, g_cross;
	level_t               grades [5];
	logic [11:0]          lane_mag;
	logic                 rear_close;
	level_t               best_lvl;
	src_t                 best_src;

	assign item.ready = push_ready;
	assign accept     = item.valid && item.ready;
	assign tgt_dist   = DIST_BITS'(item.payload.target_distance);
	assign push       = accept && (item.payload.func == FUNC_FRAME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_near_q <= '1;
			front_any_q  <= 1'b0;
			rear_near_q  <= '1;
			rear_fast_q  <= '0;
			rear_any_q   <= 1'b0;
		end else if (accept) begin
			unique case (item.payload.func)
				FUNC_FRONT: begin
					front_any_q <= 1'b1;
					if (tgt_dist < front_near_q) front_near_q <= tgt_dist;
				end
				FUNC_REAR: begin
					rear_any_q <= 1'b1;
					if (tgt_dist < rear_near_q) rear_near_q <= tgt_dist;
					if (item.payload.target_speed < rear_fast_q)
						rear_fast_q <= item.payload.target_speed;
				end
				FUNC_FRAME: begin
					// drop the frame's radar summary once graded
					front_near_q <= '1;
					front_any_q  <= 1'b0;
					rear_near_q  <= '1;
					rear_fast_q  <= '0;
					rear_any_q   <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		if (!front_any_q)
			g_front = LVL_SAFE;
		else if (CMP_W'(front_near_q) <= CMP_W'(cfg.danger))
			g_front = LVL_DANGER;
		else if (CMP_W'(front_near_q) <= CMP_W'(cfg.warning))
			g_front = LVL_WARNING;
		else if (CMP_W'(front_near_q) <= CMP_W'(cfg.attention))
			g_front = LVL_ATTENTION;
		else
			g_front = LVL_SAFE;
	end

	assign rear_close = CMP_W'(rear_near_q) < CMP_W'(cfg.rear_close);

	always_comb begin
		if (!rear_any_q)
			g_rear = LVL_SAFE;
		else if (rear_fast_q <= APPROACH_DANGER && rear_close)
			g_rear = LVL_DANGER;
		else if (rear_fast_q <= APPROACH_WARNING && rear_close)
			g_rear = LVL_WARNING;
		else if (CMP_W'(rear_near_q) <= CMP_W'(cfg.attention))
			g_rear = LVL_ATTENTION;
		else
			g_rear = LVL_SAFE;
	end

	// most negative offset has magnitude 2048, which still fits 12 unsigned bits
	assign lane_mag = item.payload.lane_offset[11] ? 12'(-item.payload.lane_offset)
		: 12'(item.payload.lane_offset);

	always_comb begin
		g_lane = LVL_SAFE;
		if (!item.payload.lane_found) begin
			g_lane = LVL_WARNING;
		end else begin
			case (item.payload.lane_place) inside
				PLACE_LOST: g_lane = LVL_WARNING;
				PLACE_LEFT, PLACE_RIGHT: begin
					if (lane_mag > {1'b0, cfg.lane_warn})
						g_lane = LVL_WARNING;
					else if (lane_mag > {1'b0, cfg.lane_att})
						g_lane = LVL_ATTENTION;
				end
				default: g_lane = LVL_SAFE;
			endcase
		end
	end

	always_comb begin
		g_light = LVL_SAFE;
		if (item.payload.light_found) begin
			case (item.payload.light_color)
				COLOR_RED:    g_light = LVL_WARNING;
				COLOR_YELLOW: g_light = LVL_ATTENTION;
				default:      g_light = LVL_SAFE;
			endcase
		end
	end

	assign g_cross = item.payload.crossing_found ? LVL_ATTENTION : LVL_SAFE;

	assign grades[0] = g_front;
	assign grades[1] = g_rear;
	assign grades[2] = g_lane;
	assign grades[3] = g_light;
	assign grades[4] = g_cross;

	// strict compare keeps the earlier source on a tie
	always_comb begin
		best_lvl = LVL_SAFE;
		best_src = SRC_FRONT;
		for (int i = 0; i < 5; i++) begin
			if (grades[i] > best_lvl) begin
				best_lvl = grades[i];
				best_src = src_t'(3'(i));
			end
		end
	end

	assign push_data.level  = best_lvl;
	assign push_data.source = best_src;
	assign push_data.dir    = (best_src == SRC_REAR) ? DIR_REAR : DIR_FRONT;

endmodule

FILE: rtl/hwfd_queue.sv
// Short register queue of graded frame choices between front and back.
`timescale 1ns / 1ps
module hwfd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hwfd_pkg::choice_t  push_data,
	output logic               push_ready,
	output logic               pop_valid,
	output hwfd_pkg::choice_t  pop_data,
	input  logic               pop
);
	import hwfd_pkg::*;
	`include "hazard_warning_fusion_debounce_top_macros.svh"

	choice_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	`HWFD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= Q_CNT_W'(Q_DEPTH), "queue count over depth")
	`HWFD_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "queue count did not advance on push")
	`HWFD_ASSERT_NOW(a_ptr_gap, 1'b1, (count_q == '0 || count_q == Q_CNT_W'(Q_DEPTH)) == (wr_ptr_q == rd_ptr_q), "queue pointers disagree with count")

endmodule

FILE: rtl/hwfd_back.sv
// Back end: debounces the graded choice and registers the result beat.
`timescale 1ns / 1ps
module hwfd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  hwfd_pkg::cfg_t     cfg,
	input  logic               pop_valid,
	input  hwfd_pkg::choice_t  pop_data,
	output logic               pop,
	hwfd_result_if.source      result
);
	import hwfd_pkg::*;
	`include "hazard_warning_fusion_debounce_top_macros.svh"

	choice_t    pend_q;
	choice_t    cur_q;
	logic [7:0] stable_q;
	logic       out_valid_q;
	result_t    out_q;

	logic       same;
	logic [7:0] stable_nx;
	choice_t    cur_nx;

	assign pop = pop_valid && (!out_valid_q || result.ready);

	always_comb begin
		same      = (pop_data == pend_q);
		stable_nx = '0;
		if (same) stable_nx = (stable_q == STABLE_MAX) ? stable_q : stable_q + 8'd1;
		cur_nx = (stable_nx >= cfg.debounce) ? pop_data : cur_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= CHOICE_RESET;
			cur_q       <= CHOICE_RESET;
			stable_q    <= '0;
			out_valid_q <= 1'b0;
		end else if (pop) begin
			pend_q      <= pop_data;
			cur_q       <= cur_nx;
			stable_q    <= stable_nx;
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.warn_level     <= cur_nx.level;
			out_q.warn_source    <= cur_nx.source;
			out_q.warn_direction <= cur_nx.dir;
			out_q.warn_active    <= (cur_nx.level != LVL_SAFE);
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	`HWFD_ASSERT_NOW(a_active_level, result.valid, result.payload.warn_active == (result.payload.warn_level != LVL_SAFE), "active flag disagrees with level")
	`HWFD_ASSERT_NEXT(a_cur_hold, !pop, $stable(cur_q) && $stable(pend_q), "choice moved without a frame")
	`HWFD_ASSERT_NEXT(a_stable_sat, pop && same && stable_q == STABLE_MAX, stable_q == STABLE_MAX, "stable counter wrapped")

endmodule

FILE: rtl/hazard_warning_fusion_debounce_top.sv
// A frame-end beat is queued on accept; the back end pops it and registers its result beat.
// Throughput: one item per cycle; the front grades on its accept edge, the back debounces
// one queued frame per cycle unless the result is stalled; the input stalls only while the
// four-entry queue is full. Radar target beats and unused item kinds give no result beat.
// Reset (arst_n low, asynchronous) restores register defaults, clears radar state,
// sets pending and current choice to safe/front radar and empties queue and output.
`timescale 1ns / 1ps
module hazard_warning_fusion_debounce_top (
	input  logic                         clk,
	input  logic                         arst_n,
	hwfd_item_if.sink                    item,
	hwfd_result_if.source                result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hwfd_pkg::ADDR_W-1:0]  paddr,
	input  logic [hwfd_pkg::DATA_W-1:0]  pwdata,
	output logic [hwfd_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import hwfd_pkg::*;

	cfg_t    cfg;
	logic    push;
	logic    push_ready;
	choice_t push_data;
	logic    pop_valid;
	logic    pop;
	choice_t pop_data;

	hwfd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hwfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item       (item),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	hwfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop        (pop)
	);

	hwfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop       (pop),
		.result    (result)
	);

endmodule

FILE: verif/hazard_warning_fusion_debounce_top_tb.sv
// Self-checking testbench for the hazard warning fusion and debounce block.
`timescale 1ns / 1ps
module hazard_warning_fusion_debounce_top_tb;
	import hwfd_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 240;
	localparam int ITEM_W       = $bits(item_t);

	localparam cfg_t RESET_SETTINGS = '{
		danger: 16'd50, warning: 16'd100, attention: 16'd200, rear_close: 16'd500,
		lane_warn: 11'd717, lane_att: 11'd410, debounce: 8'd3
	};

	localparam int SENDER_IDLE_PCT [4]    = '{0, 58, 0, 22};
	localparam int RECEIVER_STALL_PCT [4] = '{0, 0, 58, 22};

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	hwfd_item_if   item_bus ();
	hwfd_result_if result_bus ();

	hazard_warning_fusion_debounce_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted fusion state and register copy.
	cfg_t               settings      = RESET_SETTINGS;
	logic [15:0]        front_nearest = '1;
	logic               front_seen    = 1'b0;
	logic [15:0]        rear_nearest  = '1;
	logic signed [15:0] rear_fastest  = '0;
	logic               rear_seen     = 1'b0;
	choice_t            pending_pick  = CHOICE_RESET;
	logic [7:0]         stable_frames = '0;
	choice_t            current_pick  = CHOICE_RESET;

	item_t   pending_items [$];
	result_t expected_warnings [$];
	result_t oldest_warning;
	int      idle_mode      = 0;
	int      mismatch_count = 0;
	int      quiet_cycles   = 0;
	bit      beat_taken     = 1'b0;

	function automatic void fold_item(item_t beat_in);
		logic [1:0] grade [5];
		choice_t    pick;
		int         lane_mag;
		case (beat_in.func)
			FUNC_FRONT: begin
				front_seen = 1'b1;
				if (beat_in.target_distance < front_nearest)
					front_nearest = beat_in.target_distance;
			end
			FUNC_REAR: begin
				rear_seen = 1'b1;
				if (beat_in.target_distance < rear_nearest)
					rear_nearest = beat_in.target_distance;
				if ($signed(beat_in.target_speed) < rear_fastest)
					rear_fastest = $signed(beat_in.target_speed);
			end
			FUNC_FRAME: begin
				if (!front_seen)                              grade[SRC_FRONT] = LVL_SAFE;
				else if (front_nearest <= settings.danger)    grade[SRC_FRONT] = LVL_DANGER;
				else if (front_nearest <= settings.warning)   grade[SRC_FRONT] = LVL_WARNING;
				else if (front_nearest <= settings.attention) grade[SRC_FRONT] = LVL_ATTENTION;
				else                                          grade[SRC_FRONT] = LVL_SAFE;

				if (!rear_seen)
					grade[SRC_REAR] = LVL_SAFE;
				else if (rear_fastest <= APPROACH_DANGER && rear_nearest < settings.rear_close)
					grade[SRC_REAR] = LVL_DANGER;
				else if (rear_fastest <= APPROACH_WARNING && rear_nearest < settings.rear_close)
					grade[SRC_REAR] = LVL_WARNING;
				else if (rear_nearest <= settings.attention)
					grade[SRC_REAR] = LVL_ATTENTION;
				else
					grade[SRC_REAR] = LVL_SAFE;

				lane_mag = int'($signed(beat_in.lane_offset));
				if (lane_mag < 0) lane_mag = -lane_mag;
				if (!beat_in.lane_found || beat_in.lane_place == PLACE_LOST)
					grade[SRC_LANE] = LVL_WARNING;
				else if (beat_in.lane_place == PLACE_CENTER)
					grade[SRC_LANE] = LVL_SAFE;
				else if (lane_mag > int'(settings.lane_warn))
					grade[SRC_LANE] = LVL_WARNING;
				else if (lane_mag > int'(settings.lane_att))
					grade[SRC_LANE] = LVL_ATTENTION;
				else
					grade[SRC_LANE] = LVL_SAFE;

				if (!beat_in.light_found)                     grade[SRC_LIGHT] = LVL_SAFE;
				else if (beat_in.light_color == COLOR_RED)    grade[SRC_LIGHT] = LVL_WARNING;
				else if (beat_in.light_color == COLOR_YELLOW) grade[SRC_LIGHT] = LVL_ATTENTION;
				else                                          grade[SRC_LIGHT] = LVL_SAFE;

				grade[SRC_CROSS] = beat_in.crossing_found ? LVL_ATTENTION : LVL_SAFE;

				// strict compare: the earlier source keeps a tie
				pick = CHOICE_RESET;
				for (int s = 0; s < 5; s++) begin
					if (grade[s] > pick.level) begin
						pick.level  = level_t'(grade[s]);
						pick.source = src_t'(3'(s));
						pick.dir    = (s == SRC_REAR) ? DIR_REAR : DIR_FRONT;
					end
				end

				if (pick != pending_pick) begin
					pending_pick  = pick;
					stable_frames = '0;
				end else if (stable_frames < STABLE_MAX) begin
					stable_frames = stable_frames + 8'd1;
				end
				if (stable_frames >= settings.debounce)
					current_pick = pending_pick;

				front_nearest = '1;
				front_seen    = 1'b0;
				rear_nearest  = '1;
				rear_fastest  = '0;
				rear_seen     = 1'b0;

				expected_warnings.push_back('{
					warn_level:     current_pick.level,
					warn_source:    current_pick.source,
					warn_direction: current_pick.dir,
					warn_active:    current_pick.level != LVL_SAFE
				});
			end
			default: ;
		endcase
	endfunction

	function automatic item_t radar_beat(logic [1:0] kind, int range_cm, int speed);
		item_t beat_out;
		beat_out                 = item_t'(ITEM_W'({$urandom, $urandom}));
		beat_out.func            = kind;
		beat_out.target_distance = 16'(range_cm);
		beat_out.target_speed    = 16'(speed);
		return beat_out;
	endfunction

	function automatic item_t frame_beat(logic lane_found, logic [1:0] place, int offset,
		logic light_found, logic [1:0] color, logic crossing);
		item_t beat_out;
		beat_out                = item_t'(ITEM_W'({$urandom, $urandom}));
		beat_out.func           = FUNC_FRAME;
		beat_out.lane_found     = lane_found;
		beat_out.lane_place     = place;
		beat_out.lane_offset    = 12'(offset);
		beat_out.light_found    = light_found;
		beat_out.light_color    = color;
		beat_out.crossing_found = crossing;
		return beat_out;
	endfunction

	function automatic int rand_distance();
		int thr;
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 65535;
			2, 3: begin
				case ($urandom_range(0, 3))
					0: thr = int'(settings.danger);
					1: thr = int'(settings.warning);
					2: thr = int'(settings.attention);
					default: thr = int'(settings.rear_close);
				endcase
				thr = thr + int'($urandom_range(0, 2)) - 1;
				if (thr < 0) thr = 0;
				if (thr > 65535) thr = 65535;
				return thr;
			end
			4, 5: return int'($urandom_range(0, 700));
			default: return int'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic int rand_speed();
		int near_limit [6] = '{-201, -200, -199, -151, -150, -149};
		case ($urandom_range(0, 3))
			0: return near_limit[$urandom_range(0, 5)];
			1: return int'($urandom_range(0, 500)) - 400;
			default: return int'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic int rand_offset();
		int mag;
		case ($urandom_range(0, 3))
			0: begin
				mag = ($urandom_range(0, 1) == 1) ? int'(settings.lane_warn)
					: int'(settings.lane_att);
				mag = mag + int'($urandom_range(0, 2)) - 1;
				return ($urandom_range(0, 1) == 1) ? -mag : mag;
			end
			1: return int'($urandom_range(0, 4095));
			2: return ($urandom_range(0, 1) == 1) ? 2047 : -2048;
			default: return int'($urandom_range(0, 1200)) - 600;
		endcase
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DANGER:     settings.danger     = value[15:0];
			REG_WARNING:    settings.warning    = value[15:0];
			REG_ATTENTION:  settings.attention  = value[15:0];
			REG_REAR_CLOSE: settings.rear_close = value[15:0];
			REG_LANE_WARN:  settings.lane_warn  = value[10:0];
			REG_LANE_ATT:   settings.lane_att   = value[10:0];
			REG_DEBOUNCE:   settings.debounce   = value[7:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_settings(int phase);
		cfg_t s;
		case (phase)
			0: s = '0;
			1: s = '1;
			2: begin
				s          = RESET_SETTINGS;
				s.debounce = '0;
			end
			default: begin
				s.danger     = 16'($urandom_range(0, 300));
				s.warning    = s.danger + 16'($urandom_range(0, 300));
				s.attention  = 16'($urandom_range(0, 900));
				s.rear_close = 16'($urandom_range(0, 1200));
				s.lane_warn  = 11'($urandom_range(300, 2047));
				s.lane_att   = 11'($urandom_range(0, 1000));
				s.debounce   = 8'($urandom_range(0, 6));
			end
		endcase
		write_reg(REG_DANGER,     32'(s.danger));
		write_reg(REG_WARNING,    32'(s.warning));
		write_reg(REG_ATTENTION,  32'(s.attention));
		write_reg(REG_REAR_CLOSE, 32'(s.rear_close));
		write_reg(REG_LANE_WARN,  32'(s.lane_warn));
		write_reg(REG_LANE_ATT,   32'(s.lane_att));
		write_reg(REG_DEBOUNCE,   32'(s.debounce));
	endtask

	// Hold until every beat is sent and every warning seen, then let the back end drain.
	task automatic wait_idle();
		while (pending_items.size() != 0 || item_bus.valid || expected_warnings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_directed();
		item_t noise;
		noise = '1;
		pending_items.push_back(noise);
		pending_items.push_back(frame_beat(1'b1, PLACE_CENTER, 2047, 1'b1, COLOR_GREEN, 1'b0));
		pending_items.push_back(radar_beat(FUNC_FRONT, 65535, 32767));
		pending_items.push_back(frame_beat(1'b1, PLACE_CENTER, -2048, 1'b0, COLOR_OTHER, 1'b0));
		// hold a front danger long enough to pass the debounce
		repeat (4) begin
			pending_items.push_back(radar_beat(FUNC_FRONT, 0, 0));
			pending_items.push_back(frame_beat(1'b1, PLACE_CENTER, 0, 1'b0, COLOR_OTHER, 1'b0));
		end
		pending_items.push_back(radar_beat(FUNC_REAR, 10, -200));
		pending_items.push_back(radar_beat(FUNC_REAR, 499, -150));
		pending_items.push_back(frame_beat(1'b1, PLACE_CENTER, 0, 1'b0, COLOR_OTHER, 1'b0));
		pending_items.push_back(radar_beat(FUNC_REAR, 500, -32768));
		pending_items.push_back(frame_beat(1'b1, PLACE_CENTER, 0, 1'b0, COLOR_OTHER, 1'b0));
		pending_items.push_back(radar_beat(FUNC_REAR, 200, 32767));
		pending_items.push_back(frame_beat(1'b0, PLACE_CENTER, 0, 1'b0, COLOR_OTHER, 1'b0));
		pending_items.push_back(frame_beat(1'b1, PLACE_LOST, 0, 1'b1, COLOR_RED, 1'b0));
		pending_items.push_back(frame_beat(1'b1, PLACE_LEFT, -2048, 1'b1, COLOR_YELLOW, 1'b0));
		pending_items.push_back(frame_beat(1'b1, PLACE_RIGHT, 718, 1'b0, COLOR_OTHER, 1'b1));
		pending_items.push_back(frame_beat(1'b1, PLACE_RIGHT, 717, 1'b1, COLOR_OTHER, 1'b0));
		pending_items.push_back(frame_beat(1'b1, PLACE_LEFT, -410, 1'b1, COLOR_GREEN, 1'b1));
		pending_items.push_back(radar_beat(FUNC_FRONT, 150, -32768));
		pending_items.push_back(frame_beat(1'b1, PLACE_LEFT, 411, 1'b0, COLOR_OTHER, 1'b1));
	endtask

	task automatic queue_random_frames(int budget);
		item_t radar_set [$];
		item_t frame_end;
		item_t noise;
		int    queued;
		int    repeats;
		queued = 0;
		while (queued < budget) begin
			radar_set.delete();
			repeat ($urandom_range(0, 4))
				radar_set.push_back(radar_beat(($urandom_range(0, 1) == 1) ? FUNC_REAR : FUNC_FRONT,
					rand_distance(), rand_speed()));
			frame_end = frame_beat($urandom_range(0, 7) != 0, 2'($urandom_range(0, 3)),
				rand_offset(), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
				$urandom_range(0, 3) == 0);
			// repeat a frame now and then so that choices settle through the debounce
			repeats = ($urandom_range(0, 1) == 1) ? int'($urandom_range(2, 7)) : 1;
			repeat (repeats) begin
				foreach (radar_set[i]) begin
					if ($urandom_range(0, 19) == 0) begin
						noise      = item_t'(ITEM_W'({$urandom, $urandom}));
						noise.func = FUNC_SPARE;
						pending_items.push_back(noise);
					end
					pending_items.push_back(radar_set[i]);
				end
				pending_items.push_back(frame_end);
				queued += radar_set.size() + 1;
			end
		end
	endtask

	// Driver: advance to the next beat once the current one is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
		end else if (!item_bus.valid || beat_taken) begin
			if (pending_items.size() != 0
				&& $urandom_range(0, 99) >= SENDER_IDLE_PCT[idle_mode]) begin
				item_bus.payload <= pending_items.pop_front();
				item_bus.valid   <= 1'b1;
			end else begin
				item_bus.valid <= 1'b0;
			end
		end
		beat_taken = 1'b0;
		result_bus.ready <= arst_n && ($urandom_range(0, 99) >= RECEIVER_STALL_PCT[idle_mode]);
	end

	// Monitor, predictor feed and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_bus.valid && item_bus.ready) begin
				beat_taken = 1'b1;
				fold_item(item_bus.payload);
			end
			if (result_bus.valid && result_bus.ready) begin
				if (expected_warnings.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected warning beat: level %0d source %0d dir %0d active %0d",
						$time, result_bus.payload.warn_level, result_bus.payload.warn_source,
						result_bus.payload.warn_direction, result_bus.payload.warn_active);
				end else begin
					oldest_warning = expected_warnings.pop_front();
					if (result_bus.payload !== oldest_warning) begin
						mismatch_count++;
						$display("%0t: warning mismatch: expected level %0d source %0d",
							$time, oldest_warning.warn_level, oldest_warning.warn_source,
							" dir %0d active %0d,", oldest_warning.warn_direction,
							oldest_warning.warn_active,
							" got level %0d source %0d dir %0d active %0d",
							result_bus.payload.warn_level, result_bus.payload.warn_source,
							result_bus.payload.warn_direction, result_bus.payload.warn_active);
					end
				end
			end
			if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
				|| (psel && penable && pwrite))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
				$display("** hazard_warning_fusion_debounce_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		item_bus.valid   = 1'b0;
		item_bus.payload = '0;
		result_bus.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_directed();
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			apply_settings(phase);
			idle_mode = phase % 4;
			@(posedge clk);
			queue_random_frames(PHASE_ITEMS);
		end
		wait_idle();

		if (mismatch_count == 0 && expected_warnings.size() == 0)
			$display("** hazard_warning_fusion_debounce_top: PASSED **");
		else
			$display("** hazard_warning_fusion_debounce_top: FAILED **");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/hwfd_pkg.sv
rtl/hwfd_item_if.sv
rtl/hwfd_cfg.sv
rtl/hwfd_front.sv
rtl/hwfd_queue.sv
rtl/hwfd_back.sv
rtl/hazard_warning_fusion_debounce_top.sv
verif/hazard_warning_fusion_debounce_top_tb.sv
